// ===== hdl/ncsl_pkg.sv =====
// Shared constants, types and helpers for the n-gram count table.
// No dependencies; imported by ncsl_table and the top module.
`default_nettype none
package ncsl_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int TOKEN_BITS    = 20;
    localparam int KEY_W         = 62;

    localparam logic [19:0] TOKEN_MASK  = 20'((64'd1 << TOKEN_BITS) - 64'd1);
    localparam logic [63:0] HASH_MULT   = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [31:0] LN2_Q32     = 32'd2977044472;
    localparam logic [23:0] ALPHA_RESET = 24'd65536;
    localparam logic [15:0] NLP_MAX     = 16'hFFFF;
    localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;

    // request kind carried on s_tuser
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [31:0]       count;
        logic [KEY_W-1:0]  key;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        entry_t            data;
    } tbl_wr_t;

    // order in bits 61..60, tokens oldest first, unused tokens zero
    function automatic logic [KEY_W-1:0] make_key(input logic [1:0] order,
                                                  input logic [19:0] a,
                                                  input logic [19:0] b,
                                                  input logic [19:0] c);
        logic [19:0] tb;
        logic [19:0] tc;
        tb = (order >= 2'd2) ? (b & TOKEN_MASK) : 20'd0;
        tc = (order == 2'd3) ? (c & TOKEN_MASK) : 20'd0;
        return {order, a & TOKEN_MASK, tb, tc};
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ncsl_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on nothing; used by the sequencer for hashing, the denominator, squaring and scaling.
`default_nettype none
module ncsl_mul (
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic [63:0]      p
);
    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;
endmodule
`default_nettype wire

// ===== hdl/ncsl_table.sv =====
// Count table memory: one write port, one read port, registered read data.
// Depends on ncsl_pkg for the entry layout and depth.
`default_nettype none
module ncsl_table (
    input  wire logic                     clk,
    input  wire ncsl_pkg::tbl_wr_t        wr,
    input  wire logic [ncsl_pkg::IDX_W-1:0] raddr,
    output ncsl_pkg::entry_t              rdata
);
    import ncsl_pkg::*;

    entry_t mem [TABLE_ENTRIES];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ===== hdl/ngram_count_smoothed_logprob.sv =====
// Hashed n-gram count table with additive-smoothed negative log probability.
// Depends on ncsl_pkg, ncsl_mul and ncsl_table.
//
// After reset the block sweeps the table once to clear the valid bits, one
// entry a cycle, and holds s_tready low until the sweep ends; alpha writes are
// taken throughout. Each request then runs alone under a sequencer that drives
// one shared 32x32 multiplier and a table with one write and one read port.
// A request probes the home slot and the next one: the hash (three multiplies
// and a sum, S_HA to S_HD), then the reads (S_RA0 to S_RA2). An add then
// writes its slot in S_ADDW, or is dropped, and loads the output register from
// S_DONE. A query of order two or three adds a second probe for the context;
// then come the denominator (S_DEN, and S_DEN2 when unseen), a range check
// and two logarithms, each a leading-one search plus 24 squaring rounds
// (S_SQ, S_SQR), then the ln2 scaling and rounding. A query whose probability
// is at least one, or whose denominator is zero, stops after the range check,
// as does one whose numerator is zero. Order zero goes straight to S_DONE and
// gives an all-zero result. s_tready returns high as the result is loaded. The
// result sits in an output register; a new request is taken while it waits.
`default_nettype none
module ngram_count_smoothed_logprob (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request: {third_token, second_token, first_token, gram_order} from bit 0
    input  wire logic [63:0] s_tdata,
    input  wire logic        s_tuser,   // kind: 0 add, 1 query
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // result: {neg_log_prob, gram_count} from bit 0
    output logic [47:0]      m_tdata,
    output logic [1:0]       m_tuser,   // {table_full, was_seen} from bit 0
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] cfg_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready
);
    import ncsl_pkg::*;

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_HA     = 5'd2;
    localparam logic [4:0] S_HB     = 5'd3;
    localparam logic [4:0] S_HC     = 5'd4;
    localparam logic [4:0] S_HD     = 5'd5;
    localparam logic [4:0] S_RA0    = 5'd6;
    localparam logic [4:0] S_RA1    = 5'd7;
    localparam logic [4:0] S_RA2    = 5'd8;
    localparam logic [4:0] S_ADDW   = 5'd9;
    localparam logic [4:0] S_DEN    = 5'd10;
    localparam logic [4:0] S_DEN2   = 5'd11;
    localparam logic [4:0] S_CHK    = 5'd12;
    localparam logic [4:0] S_NORM   = 5'd13;
    localparam logic [4:0] S_SQ     = 5'd14;
    localparam logic [4:0] S_SQR    = 5'd15;
    localparam logic [4:0] S_LOGEND = 5'd16;
    localparam logic [4:0] S_FIN    = 5'd17;
    localparam logic [4:0] S_DONE   = 5'd18;

    // control state
    logic [4:0]       state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [31:0]      total_reg, total_next;
    logic [23:0]      alpha_reg;
    logic             ovalid_reg, ovalid_next;
    logic             ctx_phase_reg, ctx_phase_next;
    logic             log_sel_reg, log_sel_next;
    logic [4:0]       rnd_reg, rnd_next;

    // payload
    logic             kind_reg, kind_next;
    logic [1:0]       order_reg, order_next;
    logic [19:0]      ta_reg, ta_next, tb_reg, tb_next, tc_reg, tc_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [63:0]      acc_reg, acc_next;
    logic [IDX_W-1:0] slot0_reg, slot0_next;
    logic             v0_reg, v0_next, m0_reg, m0_next;
    logic [31:0]      c0_reg, c0_next;
    logic [IDX_W-1:0] wslot_reg, wslot_next;
    logic [31:0]      wcnt_reg, wcnt_next;
    logic [31:0]      cnt_reg, cnt_next;
    logic [31:0]      ctx_reg, ctx_next;
    logic [31:0]      num_reg, num_next;
    logic [63:0]      den_reg, den_next;
    logic [63:0]      x_reg, x_next;
    logic [5:0]       e_reg, e_next;
    logic [31:0]      y_reg, y_next;
    logic [23:0]      frac_reg, frac_next;
    logic [29:0]      ld_reg, ld_next;
    logic [31:0]      rcount_reg, rcount_next;
    logic [15:0]      rnlp_reg, rnlp_next;
    logic             rseen_reg, rseen_next, rfull_reg, rfull_next;
    logic [31:0]      ocount_reg, ocount_next;
    logic [15:0]      onlp_reg, onlp_next;
    logic             oseen_reg, oseen_next, ofull_reg, ofull_next;

    logic [31:0]      mul_a, mul_b;
    logic [63:0]      mul_p;
    tbl_wr_t          twr;
    logic [IDX_W-1:0] raddr;
    entry_t           rdata;

    ncsl_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    ncsl_table u_table (
        .clk   (clk),
        .wr    (twr),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic        in_acc;
    logic [IDX_W-1:0] slot1;
    logic        hit1, found;
    logic [31:0] fcount;
    logic [IDX_W-1:0] fslot;
    logic [63:0] hash;
    logic [32:0] sq;
    logic [29:0] lcur;
    logic [29:0] ldiff;
    logic [63:0] rsum;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign slot1     = slot0_reg + IDX_W'(1);
    assign hit1      = rdata.valid && (rdata.key == key_reg);
    assign found     = m0_reg || hit1;
    assign fcount    = m0_reg ? c0_reg : rdata.count;
    assign fslot     = m0_reg ? slot0_reg : slot1;
    assign hash      = acc_reg + {mul_p[31:0], 32'd0};
    assign sq        = mul_p[63:31];
    assign lcur      = {e_reg, frac_reg};
    assign ldiff     = ld_reg - lcur;
    assign rsum      = mul_p + (64'd1 << 47);

    // shared multiplier operands
    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            S_HA:
            begin
                mul_a = key_reg[31:0];
                mul_b = HASH_MULT[31:0];
            end
            S_HB:
            begin
                mul_a = {2'b00, key_reg[KEY_W-1:32]};
                mul_b = HASH_MULT[31:0];
            end
            S_HC:
            begin
                mul_a = key_reg[31:0];
                mul_b = HASH_MULT[63:32];
            end
            S_DEN:
            begin
                mul_a = total_reg;
                mul_b = (order_reg == 2'd1) ? 32'(25'h10000 + 25'(alpha_reg))
                                            : 32'(alpha_reg);
            end
            S_SQ:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            S_LOGEND:
            begin
                mul_a = 32'(ldiff);
                mul_b = LN2_Q32;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // table ports
    always_comb
    begin
        twr.we   = 1'b0;
        twr.addr = wslot_reg;
        twr.data = '{valid: 1'b1, count: wcnt_reg, key: key_reg};
        raddr    = slot0_reg;
        if (state_reg == S_CLEAR)
        begin
            twr.we   = 1'b1;
            twr.addr = clr_reg;
            twr.data = '0;
        end
        else if (state_reg == S_ADDW)
        begin
            twr.we = 1'b1;
        end
        if (state_reg == S_RA1)
        begin
            raddr = slot1;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        total_next     = total_reg;
        ovalid_next    = ovalid_reg;
        ctx_phase_next = ctx_phase_reg;
        log_sel_next   = log_sel_reg;
        rnd_next       = rnd_reg;
        kind_next      = kind_reg;
        order_next     = order_reg;
        ta_next        = ta_reg;
        tb_next        = tb_reg;
        tc_next        = tc_reg;
        key_next       = key_reg;
        acc_next       = acc_reg;
        slot0_next     = slot0_reg;
        v0_next        = v0_reg;
        m0_next        = m0_reg;
        c0_next        = c0_reg;
        wslot_next     = wslot_reg;
        wcnt_next      = wcnt_reg;
        cnt_next       = cnt_reg;
        ctx_next       = ctx_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        x_next         = x_reg;
        e_next         = e_reg;
        y_next         = y_reg;
        frac_next      = frac_reg;
        ld_next        = ld_reg;
        rcount_next    = rcount_reg;
        rnlp_next      = rnlp_reg;
        rseen_next     = rseen_reg;
        rfull_next     = rfull_reg;
        ocount_next    = ocount_reg;
        onlp_next      = onlp_reg;
        oseen_next     = oseen_reg;
        ofull_next     = ofull_reg;

        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    kind_next      = s_tuser;
                    order_next     = s_tdata[1:0];
                    ta_next        = s_tdata[21:2];
                    tb_next        = s_tdata[41:22];
                    tc_next        = s_tdata[61:42];
                    key_next       = make_key(s_tdata[1:0], s_tdata[21:2],
                                              s_tdata[41:22], s_tdata[61:42]);
                    ctx_phase_next = 1'b0;
                    rcount_next    = 32'd0;
                    rnlp_next      = 16'd0;
                    rseen_next     = 1'b0;
                    rfull_next     = 1'b0;
                    ctx_next       = 32'd0;
                    state_next     = (s_tdata[1:0] == 2'd0) ? S_DONE : S_HA;
                end
            end
            S_HA:
            begin
                state_next = S_HB;
            end
            S_HB:
            begin
                acc_next   = mul_p;
                state_next = S_HC;
            end
            S_HC:
            begin
                acc_next   = acc_reg + {mul_p[31:0], 32'd0};
                state_next = S_HD;
            end
            S_HD:
            begin
                slot0_next = hash[32 +: IDX_W];
                state_next = S_RA0;
            end
            S_RA0:
            begin
                state_next = S_RA1;
            end
            S_RA1:
            begin
                v0_next    = rdata.valid;
                m0_next    = rdata.valid && (rdata.key == key_reg);
                c0_next    = rdata.count;
                state_next = S_RA2;
            end
            S_RA2:
            begin
                if (ctx_phase_reg)
                begin
                    ctx_next   = found ? fcount : 32'd0;
                    state_next = S_DEN;
                end
                else if (kind_reg == KIND_ADD)
                begin
                    state_next = S_ADDW;
                    if (found)
                    begin
                        wslot_next = fslot;
                        wcnt_next  = (fcount == COUNT_MAX) ? fcount : fcount + 32'd1;
                        rseen_next = 1'b1;
                    end
                    else if (!v0_reg)
                    begin
                        wslot_next = slot0_reg;
                        wcnt_next  = 32'd1;
                    end
                    else if (!rdata.valid)
                    begin
                        wslot_next = slot1;
                        wcnt_next  = 32'd1;
                    end
                    else
                    begin
                        // both slots taken by other n-grams: drop
                        rfull_next = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    rseen_next  = found;
                    cnt_next    = fcount;
                    rcount_next = found ? fcount : 32'd0;
                    if (order_reg >= 2'd2)
                    begin
                        key_next       = make_key(order_reg - 2'd1, ta_reg, tb_reg, tc_reg);
                        ctx_phase_next = 1'b1;
                        state_next     = S_HA;
                    end
                    else
                    begin
                        state_next = S_DEN;
                    end
                end
            end
            S_ADDW:
            begin
                rcount_next = wcnt_reg;
                if (order_reg == 2'd1 && total_reg != COUNT_MAX)
                begin
                    total_next = total_reg + 32'd1;
                end
                state_next = S_DONE;
            end
            S_DEN:
            begin
                if (rseen_reg)
                begin
                    num_next   = cnt_reg;
                    den_next   = {32'd0, (order_reg == 2'd1) ? total_reg : ctx_reg};
                    state_next = S_CHK;
                end
                else
                begin
                    num_next   = 32'(alpha_reg);
                    state_next = S_DEN2;
                end
            end
            S_DEN2:
            begin
                den_next   = mul_p + ((order_reg == 2'd1) ? 64'd0 : {16'd0, ctx_reg, 16'd0});
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (den_reg == 64'd0 || {32'd0, num_reg} >= den_reg)
                begin
                    rnlp_next  = 16'd0;
                    state_next = S_DONE;
                end
                else if (num_reg == 32'd0)
                begin
                    rnlp_next  = NLP_MAX;
                    state_next = S_DONE;
                end
                else
                begin
                    x_next       = den_reg;
                    e_next       = 6'd63;
                    log_sel_next = 1'b0;
                    state_next   = S_NORM;
                end
            end
            S_NORM:
            begin
                // leading-one search: a byte at a time, then single bits
                if (x_reg[63:56] == 8'd0)
                begin
                    x_next = {x_reg[55:0], 8'd0};
                    e_next = e_reg - 6'd8;
                end
                else if (!x_reg[63])
                begin
                    x_next = {x_reg[62:0], 1'b0};
                    e_next = e_reg - 6'd1;
                end
                else
                begin
                    y_next     = x_reg[63:32];
                    frac_next  = 24'd0;
                    rnd_next   = 5'd0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                state_next = S_SQR;
            end
            S_SQR:
            begin
                frac_next = {frac_reg[22:0], sq[32]};
                y_next    = sq[32] ? sq[32:1] : sq[31:0];
                rnd_next  = rnd_reg + 5'd1;
                state_next = (rnd_reg == 5'd23) ? S_LOGEND : S_SQ;
            end
            S_LOGEND:
            begin
                if (!log_sel_reg)
                begin
                    ld_next      = lcur;
                    x_next       = {32'd0, num_reg};
                    e_next       = 6'd63;
                    log_sel_next = 1'b1;
                    state_next   = S_NORM;
                end
                else if (lcur >= ld_reg)
                begin
                    rnlp_next  = 16'd0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // round half up to Q8.8; the product stays far below saturation
                rnlp_next  = rsum[63:48];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    ocount_next = rcount_reg;
                    onlp_next   = rnlp_reg;
                    oseen_next  = rseen_reg;
                    ofull_next  = rfull_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            total_reg     <= 32'd0;
            alpha_reg     <= ALPHA_RESET;
            ovalid_reg    <= 1'b0;
            ctx_phase_reg <= 1'b0;
            log_sel_reg   <= 1'b0;
            rnd_reg       <= 5'd0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            total_reg     <= total_next;
            ovalid_reg    <= ovalid_next;
            ctx_phase_reg <= ctx_phase_next;
            log_sel_reg   <= log_sel_next;
            rnd_reg       <= rnd_next;
            if (cfg_valid && cfg_ready)
            begin
                alpha_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        order_reg  <= order_next;
        ta_reg     <= ta_next;
        tb_reg     <= tb_next;
        tc_reg     <= tc_next;
        key_reg    <= key_next;
        acc_reg    <= acc_next;
        slot0_reg  <= slot0_next;
        v0_reg     <= v0_next;
        m0_reg     <= m0_next;
        c0_reg     <= c0_next;
        wslot_reg  <= wslot_next;
        wcnt_reg   <= wcnt_next;
        cnt_reg    <= cnt_next;
        ctx_reg    <= ctx_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        x_reg      <= x_next;
        e_reg      <= e_next;
        y_reg      <= y_next;
        frac_reg   <= frac_next;
        ld_reg     <= ld_next;
        rcount_reg <= rcount_next;
        rnlp_reg   <= rnlp_next;
        rseen_reg  <= rseen_next;
        rfull_reg  <= rfull_next;
        ocount_reg <= ocount_next;
        onlp_reg   <= onlp_next;
        oseen_reg  <= oseen_next;
        ofull_reg  <= ofull_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {onlp_reg, ocount_reg};
    assign m_tuser  = {ofull_reg, oseen_reg};

    // one request at a time: the block drops ready right after a request
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_tready)
        else $error("request accepted while another is in progress");

    // table is written only by the clearing sweep or an add
    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        twr.we |-> (state_reg == S_CLEAR) || (state_reg == S_ADDW && kind_reg == KIND_ADD))
        else $error("table write outside clear or add");

    // a dropped add reports no count and no hit
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[31:0] == 32'd0 && !m_tuser[0]))
        else $error("dropped add carries a count");

endmodule
`default_nettype wire
